@@ hdl/pqd_pkg.sv @@
// shared constants, codes and types for the packet queue with delete and snapshot
// no dependencies; imported by pqd_cell and packet_queue_with_delete_and_snapshot
package pqd_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int FUNC_BITS   = 3;
   localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // cursor value meaning past the end
   localparam logic [CNT_BITS-1:0] CUR_NONE = CNT_BITS'(QUEUE_DEPTH);

   typedef enum logic [FUNC_BITS-1:0] {
      PQD_APPEND = 3'd0,
      PQD_PEEK   = 3'd1,
      PQD_POP    = 3'd2,
      PQD_DELETE = 3'd3,
      PQD_LOCK   = 3'd4,
      PQD_UNLOCK = 3'd5,
      PQD_NEXT   = 3'd6
   } pqd_func_type;

   typedef enum logic {
      PQD_IDLE,
      PQD_COMPACT
   } pqd_state_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic load;      // append: the cell at the tail takes the key tag
      logic mark;      // delete: every cell takes its doomed flag
      logic compact;   // doomed cells drop out, one per cycle
   } pqd_cell_cmd_type;

endpackage

@@ hdl/pqd_cell.sv @@
// one entry of the queue row: a tag, a doomed flag and the shift toward the head
// depends on pqd_pkg
module pqd_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  pqd_pkg::pqd_cell_cmd_type    cmd,
   input  logic [pqd_pkg::TAG_BITS-1:0] key_tag,
   input  logic                         load_here,
   input  logic                         mark_value,
   input  logic                         shift_in,
   input  logic [pqd_pkg::TAG_BITS-1:0] next_tag,
   input  logic                         next_doomed,
   output logic [pqd_pkg::TAG_BITS-1:0] tag,
   output logic                         doomed,
   output logic                         match,
   output logic                         shift_out
);
   import pqd_pkg::*;

   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                doomed_ff, doomed_in;
   logic                remove_here;

   // the first doomed cell starts the shift, every cell above it follows
   assign remove_here = cmd.compact & doomed_ff;
   assign shift_out   = shift_in | remove_here;
   assign match       = (tag_ff == key_tag);
   assign tag         = tag_ff;
   assign doomed      = doomed_ff;

   always_comb begin
      priority if (shift_out) begin
         tag_in = next_tag;
      end else if (cmd.load && load_here) begin
         tag_in = key_tag;
      end else begin
         tag_in = tag_ff;
      end
   end

   always_comb begin
      priority if (cmd.mark) begin
         doomed_in = mark_value;
      end else if (shift_out) begin
         doomed_in = next_doomed;
      end else begin
         doomed_in = doomed_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         doomed_ff <= 1'b0;
      end else begin
         doomed_ff <= doomed_in;
      end
   end

endmodule

@@ hdl/packet_queue_with_delete_and_snapshot.sv @@
// top level of the packet tag queue: a row of pqd_cell entries plus the
// count, cursor and lock mark control; depends on pqd_pkg and pqd_cell
//
// usage
//   - command channel: drive req_func and req_packet_tag and raise start;
//     the item is taken at the rising edge where start is high and busy low
//   - result channel: exactly one result per item, shown for one cycle with
//     rsp_strobe high; the receiver cannot stall, so it must take it then
//   - status fields (empty, full, nearly full, at end, count) describe the
//     queue after the item
// latency and throughput
//   - append, peek, pop, lock, unlock, cursor next and the unused code:
//     result in the cycle after acceptance, busy stays low, so one item
//     per cycle
//   - delete by tag: at acceptance the head alone is marked if it matches,
//     else every later matching cell, in parallel; the row then drops one
//     doomed entry per cycle, then is found clean; result follows,
//     busy high meanwhile; the single shift toward the head sets the rate
// reset
//   - synchronous, active high: queue empty, cursor past the end, no lock
//     mark; tag storage is not cleared, entries beyond the count are unread
module packet_queue_with_delete_and_snapshot (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pqd_pkg::FUNC_BITS-1:0] req_func,
   input  logic [pqd_pkg::TAG_BITS-1:0]  req_packet_tag,
   output logic                          rsp_strobe,
   output logic [pqd_pkg::TAG_BITS-1:0]  rsp_tag_out,
   output logic                          rsp_tag_valid,
   output logic                          rsp_deleted,
   output logic                          rsp_overflow,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,
   output logic                          rsp_nearly_full,
   output logic                          rsp_at_end,
   output logic [pqd_pkg::CNT_BITS-1:0]  rsp_entry_count
);
   import pqd_pkg::*;

   // bookkeeping after one entry leaves the row
   typedef struct packed {
      logic [CNT_BITS-1:0] count;
      logic [CNT_BITS-1:0] cursor;
      logic [IDX_BITS-1:0] mark_pos;
      logic                mark_valid;
   } pqd_track_type;

   function automatic pqd_track_type pqd_remove(
      input logic [IDX_BITS-1:0] idx,
      input pqd_track_type       cur
   );
      pqd_track_type nxt;
      logic [CNT_BITS-1:0] idx_wide;
      nxt      = cur;
      idx_wide = CNT_BITS'(idx);
      nxt.count = cur.count - CNT_BITS'(1);
      // cursor follows its entry, or slides to the next one
      if (cur.cursor != CUR_NONE) begin
         if (cur.cursor > idx_wide) begin
            nxt.cursor = cur.cursor - CNT_BITS'(1);
         end
         if (nxt.cursor >= nxt.count) begin
            nxt.cursor = CUR_NONE;
         end
      end
      // lock mark follows its entry, or falls back to the one before it, or clears at the head
      if (cur.mark_valid) begin
         if (cur.mark_pos > idx) begin
            nxt.mark_pos = cur.mark_pos - IDX_BITS'(1);
         end else if (cur.mark_pos == idx) begin
            if (idx == '0) begin
               nxt.mark_valid = 1'b0;
            end else begin
               nxt.mark_pos = idx - IDX_BITS'(1);
            end
         end
      end
      return nxt;
   endfunction

   // control state
   pqd_state_type       state_ff, state_in;
   pqd_track_type       track_ff, track_in;
   logic                del_found_ff, del_found_in;

   // result registers
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic                rsp_tag_valid_ff, rsp_tag_valid_in;
   logic                rsp_deleted_ff, rsp_deleted_in;
   logic                rsp_overflow_ff, rsp_overflow_in;

   // cell row
   pqd_cell_cmd_type    cell_cmd;
   logic                pop_go;
   logic [TAG_BITS-1:0] cell_tag    [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_next_tag [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_doomed, cell_next_doomed, cell_match;
   logic [QUEUE_DEPTH-1:0] cell_load_here, cell_mark_value;
   logic [QUEUE_DEPTH:0]   shift_chain;

   logic                accept;
   pqd_func_type        func;
   logic                any_doomed;
   logic [IDX_BITS-1:0] first_doomed;
   logic                head_match;
   logic                have_entries;
   logic [TAG_BITS-1:0] cursor_tag;
   logic [CNT_BITS-1:0] after_mark;

   assign func         = pqd_func_type'(req_func);
   assign accept       = start && (state_ff == PQD_IDLE);
   assign busy         = (state_ff != PQD_IDLE);
   assign have_entries = (track_ff.count != '0);
   assign head_match   = cell_match[0];
   assign cursor_tag   = cell_tag[track_ff.cursor[IDX_BITS-1:0]];
   assign shift_chain[0] = pop_go;

   // per-cell select lines
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         cell_load_here[k]  = (CNT_BITS'(k) == track_ff.count);
         // head alone when it matches, otherwise every later match
         cell_mark_value[k] = (CNT_BITS'(k) < track_ff.count) && cell_match[k]
                              && (head_match ? (k == 0) : (k != 0));
      end
   end

   // lowest doomed cell, the one that leaves this cycle
   always_comb begin
      any_doomed   = |cell_doomed;
      first_doomed = '0;
      for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
         if (cell_doomed[k]) begin
            first_doomed = IDX_BITS'(k);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         if (g == QUEUE_DEPTH - 1) begin : g_top
            assign cell_next_tag[g]    = '0;
            assign cell_next_doomed[g] = 1'b0;
         end else begin : g_mid
            assign cell_next_tag[g]    = cell_tag[g+1];
            assign cell_next_doomed[g] = cell_doomed[g+1];
         end

         pqd_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cell_cmd),
            .key_tag     (req_packet_tag),
            .load_here   (cell_load_here[g]),
            .mark_value  (cell_mark_value[g]),
            .shift_in    (shift_chain[g]),
            .next_tag    (cell_next_tag[g]),
            .next_doomed (cell_next_doomed[g]),
            .tag         (cell_tag[g]),
            .doomed      (cell_doomed[g]),
            .match       (cell_match[g]),
            .shift_out   (shift_chain[g+1])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PQD_IDLE: begin
            if (accept && (func == PQD_DELETE)) begin
               state_in = PQD_COMPACT;
            end
         end
         PQD_COMPACT: begin
            if (!any_doomed) begin
               state_in = PQD_IDLE;
            end
         end
         default: state_in = PQD_IDLE;
      endcase
   end

   // datapath and results
   always_comb begin
      track_in         = track_ff;
      del_found_in     = del_found_ff;
      cell_cmd         = '0;
      pop_go           = 1'b0;
      rsp_strobe_in    = 1'b0;
      rsp_tag_in       = '0;
      rsp_tag_valid_in = 1'b0;
      rsp_deleted_in   = 1'b0;
      rsp_overflow_in  = 1'b0;

      if (accept) begin
         rsp_strobe_in = 1'b1;
         case (func)
            PQD_APPEND: begin
               if (track_ff.count < CNT_BITS'(QUEUE_DEPTH)) begin
                  cell_cmd.load  = 1'b1;
                  track_in.count = track_ff.count + CNT_BITS'(1);
               end else begin
                  rsp_overflow_in = 1'b1;
               end
            end
            PQD_PEEK: begin
               if (have_entries) begin
                  rsp_tag_in       = cell_tag[0];
                  rsp_tag_valid_in = 1'b1;
               end
            end
            PQD_POP: begin
               if (have_entries) begin
                  rsp_tag_in       = cell_tag[0];
                  rsp_tag_valid_in = 1'b1;
                  pop_go           = 1'b1;
                  track_in         = pqd_remove('0, track_ff);
               end
            end
            PQD_DELETE: begin
               // result comes once the row is compacted
               rsp_strobe_in = 1'b0;
               cell_cmd.mark = 1'b1;
               del_found_in  = |cell_mark_value;
            end
            PQD_LOCK: begin
               if (have_entries) begin
                  track_in.cursor     = '0;
                  track_in.mark_pos   = IDX_BITS'(track_ff.count - CNT_BITS'(1));
                  track_in.mark_valid = 1'b1;
               end else begin
                  track_in.cursor     = CUR_NONE;
                  track_in.mark_valid = 1'b0;
               end
            end
            PQD_UNLOCK: begin
               track_in.mark_valid = 1'b0;
            end
            PQD_NEXT: begin
               if (track_ff.cursor < track_ff.count) begin
                  rsp_tag_in       = cursor_tag;
                  rsp_tag_valid_in = 1'b1;
                  if ((track_ff.cursor + CNT_BITS'(1)) < track_ff.count) begin
                     track_in.cursor = track_ff.cursor + CNT_BITS'(1);
                  end else begin
                     track_in.cursor = CUR_NONE;
                  end
               end
            end
            default: begin
               // unused code: status only
            end
         endcase
      end else if (state_ff == PQD_COMPACT) begin
         cell_cmd.compact = 1'b1;
         if (any_doomed) begin
            track_in = pqd_remove(first_doomed, track_ff);
         end else begin
            rsp_strobe_in  = 1'b1;
            rsp_deleted_in = del_found_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= PQD_IDLE;
         track_ff.count      <= '0;
         track_ff.cursor     <= CUR_NONE;
         track_ff.mark_pos   <= '0;
         track_ff.mark_valid <= 1'b0;
         del_found_ff        <= 1'b0;
         rsp_strobe_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         track_ff      <= track_in;
         del_found_ff  <= del_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tag_ff       <= rsp_tag_in;
      rsp_tag_valid_ff <= rsp_tag_valid_in;
      rsp_deleted_ff   <= rsp_deleted_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

   // status reflects the committed state during the strobe cycle
   always_comb begin
      if (track_ff.mark_valid) begin
         after_mark = CNT_BITS'(track_ff.mark_pos) + CNT_BITS'(1);
         if (after_mark >= track_ff.count) begin
            after_mark = CUR_NONE;
         end
         rsp_at_end = (after_mark == track_ff.cursor);
      end else begin
         after_mark = CUR_NONE;
         rsp_at_end = (track_ff.cursor == CUR_NONE);
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_tag_out     = rsp_tag_ff;
   assign rsp_tag_valid   = rsp_tag_valid_ff;
   assign rsp_deleted     = rsp_deleted_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_is_empty    = (track_ff.count == '0);
   assign rsp_is_full     = (track_ff.count == CNT_BITS'(QUEUE_DEPTH));
   assign rsp_nearly_full = (track_ff.count == CNT_BITS'(QUEUE_DEPTH - 1));
   assign rsp_entry_count = track_ff.count;

endmodule
